// ===== design/bhpq_pkg.sv =====
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned EXT_W          = 64;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_DOWN,
    S_PLACE,
    S_DONE
  } state_e;

  // Completion report from the sift engine to the result stage.
  typedef struct packed {
    logic    valid;
    status_e status;
  } done_t;

endpackage

// ===== design/bhpq_mem.sv =====
`timescale 1ns / 1ps

module bhpq_mem #(
  parameter int unsigned DEPTH      = bhpq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bhpq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_a_i,
  input  logic [AW-1:0]         raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] ram [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_a_q;
  logic [DATA_WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram[waddr_i] <= wdata_i;
    end
    rdata_a_q <= ram[raddr_a_i];
    rdata_b_q <= ram[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/bhpq_engine.sv =====
`timescale 1ns / 1ps

module bhpq_engine #(
  parameter int unsigned DEPTH      = bhpq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bhpq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned KW        = CNT_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  order_min_i,
  input  logic                  start_i,
  input  logic [1:0]            action_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  res_ready_i,
  output logic                  idle_o,
  output bhpq_pkg::done_t       done_o,
  output logic [CNT_W-1:0]      count_o,
  output logic [DATA_WIDTH-1:0] root_o,
  // memory side
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic [AW-1:0]         mem_raddr_a_o,
  output logic [AW-1:0]         mem_raddr_b_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_a_i,
  input  logic [DATA_WIDTH-1:0] mem_rdata_b_i
);

  bhpq_pkg::state_e  state_q, state_d;
  bhpq_pkg::status_e status_q, status_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] root_q, root_d;

  // True when b belongs above a under the current order.
  function automatic logic ranks_above(input logic signed [DATA_WIDTH-1:0] a,
                                       input logic signed [DATA_WIDTH-1:0] b,
                                       input logic                         omin);
    return omin ? (b < a) : (a < b);
  endfunction

  logic                  push_full, pop_empty, heap_empty;
  logic [CNT_W-1:0]      count_m1;
  logic [AW-1:0]         push_parent;
  logic [AW-1:0]         up_pos, up_parent;
  logic                  up_swap;
  logic [KW-1:0]         kid, kid_r, next_kid;
  logic                  has_r, pick_r, down_swap, next_has_kid, last_has_kid;
  logic [DATA_WIDTH-1:0] best_val;
  logic [KW-1:0]         best_idx;
  logic [AW-1:0]         up_m1;

  assign push_full   = (count_q == CNT_W'(DEPTH));
  assign pop_empty   = (count_q == '0);
  assign heap_empty  = (count_q == '0);
  assign count_m1    = count_q - CNT_W'(1);
  assign push_parent = AW'(count_m1 >> 1);

  // Sift-up: the parent of pos arrives on port A.
  assign up_pos    = AW'((pos_q - AW'(1)) >> 1);
  assign up_m1     = up_pos - AW'(1);
  assign up_parent = AW'(up_m1 >> 1);
  assign up_swap   = ranks_above(mem_rdata_a_i, val_q, order_min_i);

  // Sift-down: both children of pos arrive on ports A and B.
  assign kid          = (KW'(pos_q) << 1) + KW'(1);
  assign kid_r        = kid + KW'(1);
  assign has_r        = (kid_r < KW'(count_q));
  assign pick_r       = has_r && ranks_above(mem_rdata_a_i, mem_rdata_b_i, order_min_i);
  assign best_val     = pick_r ? mem_rdata_b_i : mem_rdata_a_i;
  assign best_idx     = pick_r ? kid_r : kid;
  assign down_swap    = ranks_above(val_q, best_val, order_min_i);
  assign next_kid     = (best_idx << 1) + KW'(1);
  assign next_has_kid = (next_kid < KW'(count_q));
  assign last_has_kid = (KW'(1) < KW'(count_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (start_i) begin
          case (action_i)
            bhpq_pkg::ACT_PUSH: begin
              state_d = (push_full || heap_empty) ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP;
            end
            bhpq_pkg::ACT_POP: begin
              state_d = pop_empty ? bhpq_pkg::S_DONE : bhpq_pkg::S_LAST;
            end
            default: begin
              state_d = bhpq_pkg::S_DONE;
            end
          endcase
        end
      end
      bhpq_pkg::S_UP: begin
        if (!up_swap) begin
          state_d = bhpq_pkg::S_DONE;
        end else if (up_pos == '0) begin
          state_d = bhpq_pkg::S_PLACE;
        end
      end
      bhpq_pkg::S_LAST: begin
        if (count_q == '0) begin
          state_d = bhpq_pkg::S_DONE;
        end else if (last_has_kid) begin
          state_d = bhpq_pkg::S_DOWN;
        end else begin
          state_d = bhpq_pkg::S_PLACE;
        end
      end
      bhpq_pkg::S_DOWN: begin
        if (!down_swap) begin
          state_d = bhpq_pkg::S_DONE;
        end else if (!next_has_kid) begin
          state_d = bhpq_pkg::S_PLACE;
        end
      end
      bhpq_pkg::S_PLACE: begin
        state_d = bhpq_pkg::S_DONE;
      end
      bhpq_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = bhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d       = count_q;
    pos_d         = pos_q;
    val_d         = val_q;
    status_d      = status_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = val_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    unique case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (start_i) begin
          status_d = bhpq_pkg::ST_OK;
          case (action_i)
            bhpq_pkg::ACT_PUSH: begin
              if (push_full) begin
                status_d = bhpq_pkg::ST_PUSH_FULL;
              end else begin
                count_d       = count_q + CNT_W'(1);
                val_d         = value_i;
                pos_d         = AW'(count_q);
                mem_raddr_a_o = push_parent;
                if (heap_empty) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = '0;
                  mem_wdata_o = value_i;
                end
              end
            end
            bhpq_pkg::ACT_POP: begin
              if (pop_empty) begin
                status_d = bhpq_pkg::ST_POP_EMPTY;
              end else begin
                count_d       = count_m1;
                mem_raddr_a_o = AW'(count_m1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      bhpq_pkg::S_UP: begin
        mem_we_o = 1'b1;
        if (up_swap) begin
          // Move the parent down into the hole and climb.
          mem_wdata_o   = mem_rdata_a_i;
          pos_d         = up_pos;
          mem_raddr_a_o = up_parent;
        end
      end
      bhpq_pkg::S_LAST: begin
        val_d         = mem_rdata_a_i;
        pos_d         = '0;
        mem_raddr_a_o = AW'(1);
        mem_raddr_b_o = AW'(KW'(2));
      end
      bhpq_pkg::S_DOWN: begin
        mem_we_o = 1'b1;
        if (down_swap) begin
          // Lift the better child into the hole and descend.
          mem_wdata_o   = best_val;
          pos_d         = AW'(best_idx);
          mem_raddr_a_o = AW'(next_kid);
          mem_raddr_b_o = AW'(next_kid + KW'(1));
        end
      end
      bhpq_pkg::S_PLACE: begin
        mem_we_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Mirror the root entry so the result needs no extra read.
  assign root_d = (mem_we_o && (mem_waddr_o == '0)) ? mem_wdata_o : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhpq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    val_q    <= val_d;
    root_q   <= root_d;
    status_q <= status_d;
  end

  assign idle_o        = (state_q == bhpq_pkg::S_IDLE);
  assign done_o.valid  = (state_q == bhpq_pkg::S_DONE);
  assign done_o.status = status_q;
  assign count_o       = count_q;
  assign root_o        = root_q;

endmodule

// ===== design/binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps

// Binary-heap priority queue of up to DEPTH signed entries held in one
// synchronous two-read, one-write memory. Each input item pushes value_i
// (action 0), pops the top entry (action 1) or peeks (action 2; the unused
// code 3 also peeks), and yields exactly one result item: the root value
// (zero when empty), the entry count, an empty flag and a status (0 ok,
// 1 pop on empty ignored, 2 push on full dropped). order_min, written
// through the cfg channel while the block is idle, keeps the smallest
// value on top when set and the largest when clear; held entries are not
// reordered when it changes. Sifting moves a hole rather than swapping, one
// heap level per cycle: each level costs one memory read whose data returns
// the next cycle, where the compare, the write-back and the next read issue
// together. A sift walks at most log2(DEPTH) levels, so 8 at the default
// depth. The next item is accepted as soon as the current result moves
// into the output register, even while that result waits for out_ready_i.
// The memory needs no clearing after reset: only entries below the count
// are ever used.

module binary_heap_priority_queue #(
  parameter int unsigned DEPTH      = bhpq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bhpq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_order_min_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic signed [bhpq_pkg::VALUE_W-1:0] value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bhpq_pkg::VALUE_W-1:0] top_value_o,
  output logic [CNT_W-1:0]                    entry_count_o,
  output logic                                is_empty_o,
  output logic [1:0]                          status_o
);

  logic order_min_q;

  logic                  eng_idle;
  bhpq_pkg::done_t       eng_done;
  logic [CNT_W-1:0]      eng_count;
  logic [DATA_WIDTH-1:0] eng_root;
  logic                  res_ready;
  logic                  res_load;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr_a;
  logic [AW-1:0]         mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_rdata_a;
  logic [DATA_WIDTH-1:0] mem_rdata_b;

  logic [bhpq_pkg::EXT_W-1:0]          value_ext;
  logic [DATA_WIDTH-1:0]               value_store;
  logic signed [DATA_WIDTH-1:0]        root_s;
  logic [bhpq_pkg::EXT_W-1:0]          root_ext;
  logic signed [bhpq_pkg::VALUE_W-1:0] top_value;

  logic                                out_valid_q, out_valid_d;
  logic signed [bhpq_pkg::VALUE_W-1:0] top_value_q;
  logic [CNT_W-1:0]                    entry_count_q;
  logic                                is_empty_q;
  logic [1:0]                          status_q;

  // Configuration register: always ready; the user must write it only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_min_q <= 1'b0;
    end else if (cfg_valid_i) begin
      order_min_q <= cfg_order_min_i;
    end
  end

  // Sign-extend the pushed value, keep its low DATA_WIDTH bits.
  assign value_ext   = bhpq_pkg::EXT_W'(value_i);
  assign value_store = value_ext[DATA_WIDTH-1:0];

  assign in_ready_o = eng_idle;

  bhpq_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .order_min_i   (order_min_q),
    .start_i       (in_valid_i),
    .action_i      (action_i),
    .value_i       (value_store),
    .res_ready_i   (res_ready),
    .idle_o        (eng_idle),
    .done_o        (eng_done),
    .count_o       (eng_count),
    .root_o        (eng_root),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  bhpq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Widen the stored root back to the result width; report zero when empty.
  assign root_s    = eng_root;
  assign root_ext  = bhpq_pkg::EXT_W'(root_s);
  assign top_value = (eng_count == '0) ? '0 : root_ext[bhpq_pkg::VALUE_W-1:0];

  // Output register: take a new result when empty or being drained.
  assign res_ready   = !out_valid_q || out_ready_i;
  assign res_load    = eng_done.valid && res_ready;
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      top_value_q   <= top_value;
      entry_count_q <= eng_count;
      is_empty_q    <= (eng_count == '0);
      status_q      <= eng_done.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_value_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign status_o      = status_q;

endmodule
